@@ rtl/mglu_pkg.sv @@
`default_nettype none
package mglu_pkg;

  localparam int unsigned OPND_W = 32;
  localparam int unsigned EXP_W  = 63;
  localparam int unsigned RES_W  = 64;
  localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

  typedef enum logic [1:0] {
    OP_POW = 2'd0,
    OP_INV = 2'd1,
    OP_GCD = 2'd2,
    OP_LCM = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [31:0]      operand_a;
    logic [31:0]      operand_b;
    logic [EXP_W-1:0] exponent;
  } in_req_t;

  typedef struct packed {
    logic [RES_W-1:0] result;
    logic             error;
  } out_req_t;

  // divider handshake between sequencer and shared divide unit
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

@@ rtl/mglu_div.sv @@
`default_nettype none
// Restoring divider: 2W-bit dividend by W-bit divisor, one quotient bit a cycle.
// Divisor zero is never issued by the sequencer unless the modulus is rewritten to zero mid-request.
module mglu_div
  import mglu_pkg::*;
#(
  parameter int unsigned W = OPND_W
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire div_ctl_t       ctl,
  input  wire logic [2*W-1:0] dividend,
  input  wire logic [W-1:0]   divisor,
  output div_sts_t            sts,
  output logic      [2*W-1:0] quot,
  output logic      [W-1:0]   rem
);
  localparam int unsigned CW = $clog2(2*W+1);

  logic [W:0]     rem_r, rem_nxt;
  logic [2*W-1:0] q_r, q_nxt;
  logic [W-1:0]   d_r, d_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0]     trial;
  logic [W:0]     diff;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[W-1:0], q_r[2*W-1]};
    diff     = trial - {1'b0, d_r};
    if (ctl.start) begin
      rem_nxt  = '0;
      q_nxt    = dividend;
      d_nxt    = divisor;
      cnt_nxt  = CW'(2*W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = diff;
        q_nxt   = {q_r[2*W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[2*W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = q_r;
  assign rem      = rem_r[W-1:0];
endmodule
`default_nettype wire

@@ rtl/modexp_gcd_lcm_unit_top.sv @@
`default_nettype none
// Channel   Direction  Signals                           Payload
// in        input      in_valid / in_stall (out)         in_req_t: opcode, a, b, exponent
// out       output     out_valid / out_stall (in)        out_req_t: result, error
// cfg       input      cfg_we / cfg_wdata                modulus register
//
// Each modular multiply step is one divider pass; with modulus 0 the result
// wraps mod 2^W and no pass is made. Power squares once per exponent bit below
// the highest set one and multiplies once per set bit, on the single shared divider.
// Gcd takes one divide per Euclid step; lcm adds one divide and a multiply.
// Reset is synchronous active low; modulus returns to 1000000007.
// in_stall is high from acceptance until the result leaves the output
// register; one request in flight at a time.
module modexp_gcd_lcm_unit_top
  import mglu_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OPND_W
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_req_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_req_t      out_data,
  input  wire logic     cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned EW = EXP_W;

  typedef enum logic [3:0] {
    S_IDLE, S_POW_CHK, S_MUL_ACC, S_WAIT_ACC, S_MUL_SQ, S_WAIT_SQ,
    S_GCD_CHK, S_WAIT_GCD, S_LCM_DIV, S_WAIT_LCM, S_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [31:0]     modulus_r;
  logic [1:0]      op_r, op_nxt;
  logic [W-1:0]    acc_r, acc_nxt;   // power accumulator / gcd x
  logic [W-1:0]    base_r, base_nxt; // power base / gcd y
  logic [W-1:0]    a_r, a_nxt, b_r, b_nxt;
  logic [EW-1:0]   e_r, e_nxt;
  logic            trunc_r, trunc_nxt; // modulus 0 => mod 2^W
  logic            acc_one_r, acc_one_nxt; // accumulator still exact 1
  logic [RES_W-1:0] res_r, res_nxt;
  logic            err_r, err_nxt;
  logic            ovalid_r, ovalid_nxt;

  logic [2*W-1:0]  mul_p;
  logic [W-1:0]    mul_x, mul_y;
  div_ctl_t        dctl;
  div_sts_t        dsts;
  logic [2*W-1:0]  dvd;
  logic [W-1:0]    dvs;
  logic [2*W-1:0]  dquot;
  logic [W-1:0]    drem;
  logic [W-1:0]    mod_w;

  assign mod_w = modulus_r[W-1:0];

  // shared multiplier, result fed to divider dividend (registered there)
  always_comb begin
    mul_x = acc_r;
    mul_y = base_r;
    case (state_r)
      S_MUL_SQ:   begin mul_x = base_r; mul_y = base_r; end
      S_LCM_DIV:  begin mul_x = '0;     mul_y = '0;     end
      S_WAIT_LCM: begin mul_x = acc_r;  mul_y = b_r;    end
      default:    begin mul_x = acc_r;  mul_y = base_r; end
    endcase
  end
  assign mul_p = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};

  mglu_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(dvd), .divisor(dvs),
    .sts(dsts), .quot(dquot), .rem(drem)
  );

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    acc_nxt     = acc_r;
    base_nxt    = base_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    e_nxt       = e_r;
    trunc_nxt   = trunc_r;
    acc_one_nxt = acc_one_r;
    res_nxt     = res_r;
    err_nxt     = err_r;
    ovalid_nxt  = ovalid_r;
    dctl.start  = 1'b0;
    dvd         = mul_p;
    dvs         = mod_w;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_data.opcode;
          a_nxt       = in_data.operand_a[W-1:0];
          b_nxt       = in_data.operand_b[W-1:0];
          acc_nxt     = '0;
          acc_one_nxt = 1'b1;
          base_nxt    = in_data.operand_a[W-1:0];
          trunc_nxt   = (mod_w == '0);
          err_nxt     = 1'b0;
          if (in_data.opcode == OP_POW) begin
            e_nxt     = in_data.exponent;
            state_nxt = S_POW_CHK;
          end else if (in_data.opcode == OP_INV) begin
            if (mod_w < W'(2)) e_nxt = '0;
            else e_nxt = EW'(mod_w - W'(2));
            state_nxt = S_POW_CHK;
          end else begin
            acc_nxt   = in_data.operand_a[W-1:0];
            base_nxt  = in_data.operand_b[W-1:0];
            state_nxt = S_GCD_CHK;
          end
        end
      end
      S_POW_CHK: begin
        if (e_r == '0) begin
          res_nxt    = acc_one_r ? RES_W'(1) : RES_W'(acc_r);
          ovalid_nxt = 1'b1;
          state_nxt  = S_OUT;
        end else if (e_r[0]) begin
          if (acc_one_r) begin
            // 1 * base mod m: reduce base alone
            dvd = {{W{1'b0}}, base_r};
          end
          if (trunc_r) begin
            acc_nxt     = acc_one_r ? base_r : mul_p[W-1:0];
            acc_one_nxt = 1'b0;
            state_nxt   = S_MUL_SQ;
          end else begin
            dctl.start = 1'b1;
            state_nxt  = S_WAIT_ACC;
          end
        end else begin
          state_nxt = S_MUL_SQ;
        end
      end
      S_WAIT_ACC: begin
        if (dsts.done) begin
          acc_nxt     = drem;
          acc_one_nxt = 1'b0;
          state_nxt   = S_MUL_SQ;
        end
      end
      S_MUL_SQ: begin
        e_nxt = e_r >> 1;
        if (e_r[EW-1:1] == '0) begin
          state_nxt = S_POW_CHK; // square not needed
        end else if (trunc_r) begin
          base_nxt  = mul_p[W-1:0];
          state_nxt = S_POW_CHK;
        end else begin
          dctl.start = 1'b1;
          state_nxt  = S_WAIT_SQ;
        end
      end
      S_WAIT_SQ: begin
        if (dsts.done) begin
          base_nxt  = drem;
          state_nxt = S_POW_CHK;
        end
      end
      S_GCD_CHK: begin
        if (base_r == '0) begin
          if (op_r == OP_GCD) begin
            res_nxt    = RES_W'(acc_r);
            ovalid_nxt = 1'b1;
            state_nxt  = S_OUT;
          end else if (acc_r == '0) begin
            res_nxt    = '0;
            err_nxt    = 1'b1;
            ovalid_nxt = 1'b1;
            state_nxt  = S_OUT;
          end else begin
            dvd        = {{W{1'b0}}, a_r};
            dvs        = acc_r;
            dctl.start = 1'b1;
            state_nxt  = S_LCM_DIV;
          end
        end else begin
          dvd        = {{W{1'b0}}, acc_r};
          dvs        = base_r;
          dctl.start = 1'b1;
          state_nxt  = S_WAIT_GCD;
        end
      end
      S_WAIT_GCD: begin
        if (dsts.done) begin
          acc_nxt   = base_r;
          base_nxt  = drem;
          state_nxt = S_GCD_CHK;
        end
      end
      S_LCM_DIV: begin
        if (dsts.done) begin
          acc_nxt   = dquot[W-1:0];
          state_nxt = S_WAIT_LCM;
        end
      end
      S_WAIT_LCM: begin
        // a/g times b on the shared multiplier
        res_nxt    = RES_W'(mul_p);
        ovalid_nxt = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          ovalid_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ovalid_r  <= 1'b0;
      modulus_r <= MODULUS_RESET;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) modulus_r <= cfg_wdata;
    end
    op_r      <= op_nxt;
    acc_r     <= acc_nxt;
    base_r    <= base_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    e_r       <= e_nxt;
    trunc_r   <= trunc_nxt;
    acc_one_r <= acc_one_nxt;
    res_r     <= res_nxt;
    err_r     <= err_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = ovalid_r;
  assign out_data.result = res_r;
  assign out_data.error  = err_r;

  // error only ever flagged on an lcm request
  a_err_lcm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error) |-> (op_r == OP_LCM && out_data.result == '0))
    else $error("error flag on non-lcm or nonzero result");
  // output holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("output changed under stall");
  // divider never started while already running
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    dctl.start |-> !dsts.busy)
    else $error("divider restarted while busy");
  // output valid only in output state
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_OUT))
    else $error("output valid outside output state");
endmodule
`default_nettype wire

@@ tb/modexp_gcd_lcm_unit_top_test.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Testbench for the number-theory unit: power, inverse, gcd and lcm.
// A directed table covers extremes and corner cases, then random requests
// run under several modulus settings, each result checked against an
// in-bench model of the arithmetic.
module modexp_gcd_lcm_unit_top_test;
  import mglu_pkg::*;

  localparam int unsigned W = 32;
  localparam longint unsigned LIMIT_CYCLES = 64'd10_000_000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_data;
  logic     cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  modexp_gcd_lcm_unit_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model copy of the modulus register
  logic [31:0] modulus_q = MODULUS_RESET;
  out_req_t    expected_results[$];
  int unsigned mismatch_count = 0;
  longint unsigned cycle_count = 0;
  bit          long_hold = 1'b0;   // receiver holds off for a long stretch

  // 32x32 products fit in 64 bits, so plain 64-bit math is exact
  function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y,
                                         logic [63:0] m);
    return (x * y) % m;
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] base, logic [62:0] e,
                                         logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, base, m);
      base = mulmod(base, base, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic out_req_t predict_result(in_req_t rq, logic [31:0] modv);
    out_req_t r;
    logic [63:0] a, b, m, g;
    a = rq.operand_a;
    b = rq.operand_b;
    m = modv;
    r = '0;
    case (op_t'(rq.opcode))
      OP_POW: r.result = powmod(a, rq.exponent, (m == 0) ? (64'd1 << W) : m);
      OP_INV: r.result = (m < 2) ? 64'd1 : powmod(a, 63'(m - 2), m);
      OP_GCD: r.result = euclid(a, b);
      default: begin
        g = euclid(a, b);
        if (g == 0) r.error = 1'b1;
        else r.result = (a / g) * b;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result checker: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.result, 64'd0);
      end else begin
        out_req_t want;
        want = expected_results.pop_front();
        if (out_data.result !== want.result)
          report_mismatch("result", out_data.result, want.result);
        if (out_data.error !== want.error)
          report_mismatch("error", 64'(out_data.error), 64'(want.error));
      end
    end
  end

  // receiver stall: random gaps, mostly short, some long, some runs clean
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (20000) @(posedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else begin
        n = $urandom_range(0, 9);
        if (n < 5) out_stall <= 1'b0;
        else if (n < 9) out_stall <= 1'b1;
        else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(20, 300)) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // one request: hold valid until accepted, then queue its expectation;
  // valid is dropped by the gap or drain that follows
  task automatic send_request(in_req_t rq);
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (in_stall);
    expected_results = {expected_results, predict_result(rq, modulus_q)};
  endtask

  task automatic sender_gap();
    int unsigned n;
    n = $urandom_range(0, 9);
    if (n < 4) return;
    in_valid <= 1'b0;
    if (n < 9) repeat ($urandom_range(1, 4)) @(posedge clk);
    else repeat ($urandom_range(30, 400)) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_modulus(logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    modulus_q = v;
  endtask

  function automatic logic [31:0] rand_opnd();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(0, 100));
      default: return $urandom();
    endcase
  endfunction

  function automatic in_req_t rand_request();
    in_req_t rq;
    rq.opcode    = 2'($urandom_range(0, 3));
    rq.operand_a = rand_opnd();
    rq.operand_b = rand_opnd();
    // most exponents short, a few use all 63 bits
    if ($urandom_range(0, 4) == 0) rq.exponent = 63'({$urandom(), $urandom()});
    else rq.exponent = 63'($urandom_range(0, 4095));
    return rq;
  endfunction

  // directed table: opcode, a, b, exponent, known result (check_known)
  typedef struct {
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
    logic [62:0] e;
    bit          check_known;
    logic [63:0] res;
    logic        err;
  } row_t;

  row_t dir_rows[] = '{
    '{OP_POW, 32'd5, 32'd0, 63'd0, 1, 64'd1, 1'b0},              // zero exponent
    '{OP_POW, 32'hFFFF_FFFF, 32'd0, 63'd1, 1, 64'd294967267, 1'b0}, // base reduced
    '{OP_POW, 32'd2, 32'd0, 63'd10, 1, 64'd1024, 1'b0},
    '{OP_POW, 32'hFFFF_FFFF, 32'd0, {63{1'b1}}, 0, 64'd0, 1'b0},
    '{OP_POW, 32'd0, 32'd0, 63'd5, 1, 64'd0, 1'b0},
    '{OP_INV, 32'd2, 32'd0, 63'd0, 0, 64'd0, 1'b0},
    '{OP_INV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, {63{1'b1}}, 0, 64'd0, 1'b0},
    '{OP_GCD, 32'd12, 32'd18, 63'd0, 1, 64'd6, 1'b0},
    '{OP_GCD, 32'd7, 32'd0, 63'd0, 1, 64'd7, 1'b0},
    '{OP_GCD, 32'd0, 32'd9, 63'd0, 1, 64'd9, 1'b0},
    '{OP_GCD, 32'd0, 32'd0, 63'd0, 1, 64'd0, 1'b0},
    '{OP_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 63'd0, 1, 64'd1, 1'b0},
    '{OP_LCM, 32'd0, 32'd0, 63'd0, 1, 64'd0, 1'b1},              // both zero: error
    '{OP_LCM, 32'd0, 32'd5, 63'd0, 1, 64'd0, 1'b0},
    '{OP_LCM, 32'd5, 32'd0, 63'd0, 1, 64'd0, 1'b0},
    '{OP_LCM, 32'd4, 32'd6, 63'd0, 1, 64'd12, 1'b0},
    '{OP_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 63'd0, 1, 64'hFFFF_FFFD_0000_0002, 1'b0}
  };

  // modulus settings walked by the random part; extremes included
  logic [31:0] mod_settings[] = '{32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFB, 32'd97};

  initial begin
    in_req_t rq;
    out_req_t known;
    out_req_t pred;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, with the reset modulus
    foreach (dir_rows[i]) begin
      rq.opcode    = dir_rows[i].op;
      rq.operand_a = dir_rows[i].a;
      rq.operand_b = dir_rows[i].b;
      rq.exponent  = dir_rows[i].e;
      if (dir_rows[i].check_known) begin
        known.result = dir_rows[i].res;
        known.error  = dir_rows[i].err;
        pred = predict_result(rq, modulus_q);
        if (pred !== known)
          report_mismatch("table row model", pred.result, known.result);
      end
      send_request(rq);
      sender_gap();
    end
    drain();

    // random part across modulus settings
    foreach (mod_settings[k]) begin
      write_modulus(mod_settings[k]);
      // inverse with modulus below 2 or equal 2 yields 1
      if (mod_settings[k] <= 2) begin
        rq = rand_request();
        rq.opcode = OP_INV;
        send_request(rq);
      end
      for (int j = 0; j < 20; j++) begin
        if (k == 3 && j == 5) long_hold = 1'b1;
        send_request(rand_request());
        if (!long_hold) sender_gap();
      end
      drain();
    end

    // back to reset value so the register sees it written too
    write_modulus(MODULUS_RESET);
    for (int j = 0; j < 4; j++) send_request(rand_request());
    drain();

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ modexp_gcd_lcm_unit_top.f @@
rtl/mglu_pkg.sv
rtl/mglu_div.sv
rtl/modexp_gcd_lcm_unit_top.sv
tb/modexp_gcd_lcm_unit_top_test.sv
